// ----- sv/mshull_pkg.sv -----
// mshull_pkg: shared constants, types, state codes and point ordering for the hull block
// no dependencies
`default_nettype none
package mshull_pkg;
  localparam int MAX_FIRST  = 8;
  localparam int MAX_SECOND = 8;
  localparam int COORD_BITS = 24;
  localparam int MAX_SUMS   = MAX_FIRST * MAX_SECOND;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int IDX_BITS   = $clog2(MAX_SUMS);
  localparam int CNT_BITS   = $clog2(MAX_SUMS + 1);
  localparam int FC_BITS    = $clog2(MAX_FIRST + 1);
  localparam int SC_BITS    = $clog2(MAX_SECOND + 1);
  localparam int FI_BITS    = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
  localparam int SI_BITS    = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
  localparam int DIFF_BITS  = OUT_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DIST_BITS  = PROD_BITS + 1;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_HULL   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0] sum_t;
  typedef struct packed {
    sum_t x;
    sum_t y;
  } spt_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GEN_RD, S_GEN_WR, S_PIV_RD, S_PIV_CMP, S_SWAP_RD, S_SWAP_WR,
    S_INS_RDV, S_INS_RDJ, S_INS_CMP, S_INS_MUL, S_INS_DEC, S_INS_PUT,
    S_SC_RDC, S_SC_RDT, S_SC_RDU, S_SC_MUL, S_SC_DEC,
    S_OUT_RD, S_OUT_WAIT, S_OUT_SHOW, S_EMPTY
  } state_t;

  function automatic logic pt_less(spt_t a, spt_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction
endpackage
`default_nettype wire

// ----- sv/mshull_ram.sv -----
// mshull_ram: generic single-port write, single read-port memory, registered read
// no dependencies
`default_nettype none
module mshull_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/mshull_turn.sv -----
// mshull_turn: registered cross-product and distance terms for three points
// depends on mshull_pkg
`default_nettype none
module mshull_turn (
  input  wire logic             clk,
  input  wire mshull_pkg::spt_t o,
  input  wire mshull_pkg::spt_t p,
  input  wire mshull_pkg::spt_t q,
  output logic                  left,
  output logic                  straight,
  output logic                  p_nearer
);
  import mshull_pkg::*;
  logic signed [DIFF_BITS-1:0] pdx, pdy, qdx, qdy;
  logic signed [PROD_BITS-1:0] l, r, pxx, pyy, qxx, qyy;
  logic [DIST_BITS-1:0] dp, dq;
  always_comb begin
    pdx = DIFF_BITS'(p.x) - DIFF_BITS'(o.x);
    pdy = DIFF_BITS'(p.y) - DIFF_BITS'(o.y);
    qdx = DIFF_BITS'(q.x) - DIFF_BITS'(o.x);
    qdy = DIFF_BITS'(q.y) - DIFF_BITS'(o.y);
  end
  always_ff @(posedge clk) begin
    l   <= PROD_BITS'(pdx) * PROD_BITS'(qdy);
    r   <= PROD_BITS'(pdy) * PROD_BITS'(qdx);
    pxx <= PROD_BITS'(pdx) * PROD_BITS'(pdx);
    pyy <= PROD_BITS'(pdy) * PROD_BITS'(pdy);
    qxx <= PROD_BITS'(qdx) * PROD_BITS'(qdx);
    qyy <= PROD_BITS'(qdy) * PROD_BITS'(qdy);
  end
  always_comb begin
    dp = DIST_BITS'(unsigned'(pxx)) + DIST_BITS'(unsigned'(pyy));
    dq = DIST_BITS'(unsigned'(qxx)) + DIST_BITS'(unsigned'(qyy));
    left     = l > r;
    straight = l == r;
    p_nearer = dp < dq;
  end
endmodule
`default_nettype wire

// ----- sv/minkowski_sum_convex_hull_top.sv -----
// minkowski_sum_convex_hull_top: point stores, sum memory, sort and scan sequencer
// depends on mshull_pkg, mshull_ram, mshull_turn
//
//   channel | handshake          | fields
//   in      | in_valid, in_ready | kind, coord_x, coord_y
//   out     | out_valid,out_ready| hull_x, hull_y, vertex_count, last
//
// a compute forms the n sums one after another, then finds the pivot in a pass over the
// sums, then sorts them by insertion; the scan then visits each sorted sum and pops the
// stack as needed, and each vertex is read out through the stack memory and the sum
// memory; the single sum memory read port sets the pace of all of this
// no input transaction is taken while a compute runs; reset clears counts and state
// output stalls hold the current vertex
`default_nettype none
module minkowski_sum_convex_hull_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          kind,
  input  wire logic signed [mshull_pkg::COORD_BITS-1:0] coord_x,
  input  wire logic signed [mshull_pkg::COORD_BITS-1:0] coord_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mshull_pkg::OUT_BITS-1:0]   hull_x,
  output logic signed [mshull_pkg::OUT_BITS-1:0]   hull_y,
  output logic [6:0]                               vertex_count,
  output logic                                     last
);
  import mshull_pkg::*;

  coord_t fx [MAX_FIRST];
  coord_t fy [MAX_FIRST];
  coord_t gx [MAX_SECOND];
  coord_t gy [MAX_SECOND];
  logic [FC_BITS-1:0] fcnt;
  logic [SC_BITS-1:0] scnt;

  state_t state, state_next;
  logic [CNT_BITS-1:0] n, i, j, k, sp;
  logic [FI_BITS-1:0] ia;
  logic [SI_BITS-1:0] ib;
  spt_t piv, v, a, cur, t1;
  logic popped;

  // sum memory and hull stack memory
  logic s_we;
  logic [IDX_BITS-1:0] s_wa, s_ra;
  spt_t s_wd, s_rd;
  logic h_we;
  logic [IDX_BITS-1:0] h_wa, h_ra, h_rd;

  mshull_ram #(.WIDTH(2*OUT_BITS), .DEPTH(MAX_SUMS)) u_sums (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  mshull_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_SUMS)) u_stack (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(i[IDX_BITS-1:0]), .raddr(h_ra),
    .rdata(h_rd)
  );

  spt_t to, tp, tq;
  logic t_left, t_straight, t_near;
  mshull_turn u_turn (
    .clk(clk), .o(to), .p(tp), .q(tq),
    .left(t_left), .straight(t_straight), .p_nearer(t_near)
  );

  // phase of two-step reads and compares inside sort, scan and output states
  logic ph;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT_SHOW) || (state == S_EMPTY);

  always_comb begin
    to = piv;
    tp = v;
    tq = a;
    if (state == S_SC_MUL) begin
      to = s_rd;
      tp = t1;
      tq = cur;
    end
  end

  always_comb begin
    state_next = state;
    s_we = 1'b0;
    s_wa = n[IDX_BITS-1:0];
    s_wd.x = OUT_BITS'(fx[ia]) + OUT_BITS'(gx[ib]);
    s_wd.y = OUT_BITS'(fy[ia]) + OUT_BITS'(gy[ib]);
    s_ra = i[IDX_BITS-1:0];
    h_we = 1'b0;
    h_wa = sp[IDX_BITS-1:0];
    h_ra = IDX_BITS'(sp - CNT_BITS'(1));
    case (state)
      S_IDLE: begin
        if (in_valid && kind == KIND_HULL) begin
          state_next = (fcnt == '0 || scnt == '0) ? S_EMPTY : S_GEN_WR;
        end
      end
      S_GEN_WR: begin
        s_we = 1'b1;
        if (32'(ib) + 1 >= 32'(scnt) && 32'(ia) + 1 >= 32'(fcnt)) begin
          state_next = S_PIV_RD;
        end
      end
      S_PIV_RD: begin
        s_ra = i[IDX_BITS-1:0];
        state_next = S_PIV_CMP;
      end
      S_PIV_CMP: begin
        s_ra = i[IDX_BITS-1:0];
        if (i == n) begin
          state_next = S_SWAP_RD;
        end
      end
      S_SWAP_RD: begin
        // slot zero takes the pivot, its old content is read out at the same time
        s_ra = '0;
        s_we = 1'b1;
        s_wa = '0;
        s_wd = piv;
        state_next = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        s_we = 1'b1;
        s_wa = k[IDX_BITS-1:0];
        s_wd = s_rd;
        state_next = S_INS_RDV;
      end
      S_INS_RDV: begin
        if (i >= n) begin
          state_next = S_SC_RDC;
        end else begin
          s_ra = i[IDX_BITS-1:0];
          state_next = S_INS_RDJ;
        end
      end
      S_INS_RDJ: begin
        if (j > CNT_BITS'(1)) begin
          s_ra = IDX_BITS'(j - CNT_BITS'(1));
          state_next = S_INS_CMP;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_CMP: state_next = S_INS_MUL;
      S_INS_MUL: begin
        if (ph) begin
          if (t_left || (t_straight && t_near)) begin
            state_next = S_INS_DEC;
          end else begin
            state_next = S_INS_PUT;
          end
        end
      end
      S_INS_DEC: begin
        s_we = 1'b1;
        s_wa = j[IDX_BITS-1:0];
        s_wd = a;
        state_next = S_INS_RDJ;
      end
      S_INS_PUT: begin
        s_we = 1'b1;
        s_wa = j[IDX_BITS-1:0];
        s_wd = v;
        state_next = S_INS_RDV;
      end
      S_SC_RDC: begin
        if (i >= n) begin
          state_next = S_OUT_RD;
        end else begin
          s_ra = i[IDX_BITS-1:0];
          state_next = S_SC_RDT;
        end
      end
      S_SC_RDT: begin
        if (sp == '0) begin
          h_we = 1'b1;
          state_next = S_SC_DEC;
        end else begin
          s_ra = h_rd;
          state_next = S_SC_RDU;
        end
      end
      S_SC_RDU: begin
        if (!ph) begin
          if (!popped && s_rd == cur) begin
            state_next = S_SC_DEC;
          end else if (sp < CNT_BITS'(2)) begin
            h_we = 1'b1;
            state_next = S_SC_DEC;
          end else begin
            h_ra = IDX_BITS'(sp - CNT_BITS'(2));
          end
        end else begin
          s_ra = h_rd;
          state_next = S_SC_MUL;
        end
      end
      S_SC_MUL: begin
        if (ph) begin
          if (!t_left) begin
            h_ra = IDX_BITS'(sp - CNT_BITS'(2));
            state_next = S_SC_RDT;
          end else begin
            h_we = 1'b1;
            state_next = S_SC_DEC;
          end
        end
      end
      S_SC_DEC: state_next = S_SC_RDC;
      S_OUT_RD: begin
        h_ra = k[IDX_BITS-1:0];
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (ph) begin
          state_next = S_OUT_SHOW;
        end
        h_ra = k[IDX_BITS-1:0];
        s_ra = h_rd;
      end
      S_OUT_SHOW: begin
        h_ra = k[IDX_BITS-1:0];
        s_ra = h_rd;
        if (out_ready) begin
          state_next = (k + CNT_BITS'(1) == sp) ? S_IDLE : S_OUT_RD;
        end
      end
      S_EMPTY: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fcnt <= '0;
      scnt <= '0;
      sp <= '0;
      ph <= 1'b0;
      popped <= 1'b0;
    end else begin
      state <= state_next;
      ph <= (state_next == state) ? ~ph : 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind == KIND_FIRST && 32'(fcnt) < MAX_FIRST) begin
              fx[fcnt[FI_BITS-1:0]] <= coord_x;
              fy[fcnt[FI_BITS-1:0]] <= coord_y;
              fcnt <= fcnt + FC_BITS'(1);
            end
            if (kind == KIND_SECOND && 32'(scnt) < MAX_SECOND) begin
              gx[scnt[SI_BITS-1:0]] <= coord_x;
              gy[scnt[SI_BITS-1:0]] <= coord_y;
              scnt <= scnt + SC_BITS'(1);
            end
            n <= '0;
            ia <= '0;
            ib <= '0;
            i <= '0;
            k <= '0;
            if (kind == KIND_HULL) begin
              sp <= '0;
              if (fcnt == '0 || scnt == '0) begin
                fcnt <= '0;
                scnt <= '0;
              end
            end
          end
        end
        S_GEN_WR: begin
          n <= n + CNT_BITS'(1);
          if (32'(ib) + 1 >= 32'(scnt)) begin
            ib <= '0;
            ia <= ia + FI_BITS'(1);
          end else begin
            ib <= ib + SI_BITS'(1);
          end
          if (state_next == S_PIV_RD) begin
            fcnt <= '0;
            scnt <= '0;
            i <= '0;
          end
        end
        S_PIV_RD: begin
          i <= i + CNT_BITS'(1);
          k <= '0;
        end
        S_PIV_CMP: begin
          if (i == CNT_BITS'(1) || pt_less(s_rd, piv)) begin
            piv <= s_rd;
            k <= i - CNT_BITS'(1);
          end
          if (i != n) i <= i + CNT_BITS'(1);
        end
        S_SWAP_WR: begin
          i <= CNT_BITS'(2);
        end
        S_INS_RDV: begin
          if (i >= n) begin
            i <= '0;
            k <= '0;
          end else begin
            j <= i;
          end
        end
        S_INS_RDJ: begin
          if (!ph) v <= (j == i) ? s_rd : v;
        end
        S_INS_CMP: a <= s_rd;
        S_INS_DEC: j <= j - CNT_BITS'(1);
        S_INS_PUT: i <= i + CNT_BITS'(1);
        S_SC_RDT: begin
          cur <= s_rd;
          if (sp == '0) sp <= sp + CNT_BITS'(1);
        end
        S_SC_RDU: begin
          if (!ph) begin
            t1 <= s_rd;
            if (!(!popped && s_rd == cur) && sp < CNT_BITS'(2)) sp <= sp + CNT_BITS'(1);
          end
        end
        S_SC_MUL: begin
          if (ph) begin
            if (!t_left) begin
              sp <= sp - CNT_BITS'(1);
              popped <= 1'b1;
            end else begin
              sp <= sp + CNT_BITS'(1);
            end
          end
        end
        S_SC_DEC: begin
          i <= i + CNT_BITS'(1);
          popped <= 1'b0;
        end
        S_OUT_SHOW: if (out_ready) k <= k + CNT_BITS'(1);
        default: ;
      endcase
      if (state == S_SWAP_RD) i <= '0;
    end
  end

  assign hull_x = (state == S_EMPTY) ? '0 : s_rd.x;
  assign hull_y = (state == S_EMPTY) ? '0 : s_rd.y;
  assign vertex_count = (state == S_EMPTY) ? 7'd0 : 7'(sp);
  assign last = (state == S_EMPTY) || (k + CNT_BITS'(1) == sp);
endmodule
`default_nettype wire
